[hw/rtl/page_bitmap_allocator_macros.svh]
// Assertion macros for the page bitmap allocator.
// Used by the top level only; no other dependencies.
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// Generic clocked assertion with a reset disable
`define PBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock and reset
`define PBA_ASSERT_CLK(label, prop, msg) \
   `PBA_ASSERT(label, clock, reset, prop, msg)

`endif

[hw/rtl/pba_pkg.sv]
// Shared types, constants and helpers for the page bitmap allocator.
// No dependencies.
`default_nettype none
package pba_pkg;

   localparam int MAX_PAGES = 4096;
   localparam int PAGE_W    = 12;
   localparam int CNT_W     = 13;
   localparam int ADDR_W    = 14;
   localparam logic [PAGE_W-1:0] HINT_MAX = PAGE_W'(MAX_PAGES - 1);
   localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_PAGES);

   typedef enum logic [1:0] {
      CMD_INIT      = 2'd0,
      CMD_ALLOC_ONE = 2'd1,
      CMD_ALLOC_RUN = 2'd2,
      CMD_FREE      = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_FIRST_USABLE = 1'b0,
      CSR_PAGE_COUNT   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_ONE_CHECK,
      ST_ONE_READ,
      ST_ONE_EVAL,
      ST_RUN_CHECK,
      ST_RUN_READ,
      ST_RUN_EVAL,
      ST_FIN,
      ST_RESP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic rd_one;
      logic rd_run;
      logic one_hit;
      logic one_miss;
      logic run_used;
      logic run_free;
      logic fill_step;
      logic fail;
      logic finish;
      logic respond;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic one_live;
      logic run_live;
      logic run_fit;
      logic page_used;
      logic fill_done;
      logic rsp_open;
   } dp_stat_type;

   function automatic logic [PAGE_W-1:0] hint_clamp(input logic [ADDR_W-1:0] v);
      return (v > ADDR_W'(HINT_MAX)) ? HINT_MAX : v[PAGE_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] count_sub(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] n);
      return (n > c) ? '0 : c - n;
   endfunction

   function automatic logic [CNT_W-1:0] count_add(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] n);
      logic [CNT_W:0] s;
      s = {1'b0, c} + {1'b0, n};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/pba_ctrl.sv]
// Controller state machine for the page bitmap allocator.
// Depends on pba_pkg; drives the datapath command struct.
`default_nettype none
module pba_ctrl
   import pba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (cmd_type'(req_command))
                  CMD_INIT:      state_in = ST_FILL;
                  CMD_ALLOC_ONE: state_in = ST_ONE_CHECK;
                  CMD_ALLOC_RUN: state_in = ST_RUN_CHECK;
                  CMD_FREE:      state_in = ST_FILL;
                  default:       state_in = ST_FILL;
               endcase
            end
         end
         ST_FILL: begin
            if (stat.fill_done) begin
               state_in = ST_FIN;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_ONE_CHECK: begin
            if (stat.one_live) begin
               state_in = ST_ONE_READ;
            end else begin
               cmd.fail = 1'b1;
               state_in = ST_FIN;
            end
         end
         ST_ONE_READ: begin
            cmd.rd_one = 1'b1;
            state_in   = ST_ONE_EVAL;
         end
         ST_ONE_EVAL: begin
            if (stat.page_used) begin
               cmd.one_miss = 1'b1;
               state_in     = ST_ONE_CHECK;
            end else begin
               cmd.one_hit = 1'b1;
               state_in    = ST_FIN;
            end
         end
         ST_RUN_CHECK: begin
            priority if (!stat.run_live) begin
               cmd.fail = 1'b1;
               state_in = ST_FIN;
            end else if (stat.run_fit) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_RUN_READ;
            end
         end
         ST_RUN_READ: begin
            cmd.rd_run = 1'b1;
            state_in   = ST_RUN_EVAL;
         end
         ST_RUN_EVAL: begin
            if (stat.page_used) begin
               cmd.run_used = 1'b1;
            end else begin
               cmd.run_free = 1'b1;
            end
            state_in = ST_RUN_CHECK;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_open) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/pba_dp.sv]
// Datapath for the page bitmap allocator: bitmap memory, hints, counters,
// config registers and result register. Depends on pba_pkg.
`default_nettype none
module pba_dp
   import pba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   output dp_stat_type            stat,
   input  wire logic [1:0]        req_command,
   input  wire logic [PAGE_W-1:0] req_page_index,
   input  wire logic [CNT_W-1:0]  req_run_length,
   input  wire logic              csr_write_enable,
   input  wire logic [0:0]        csr_index,
   input  wire logic [CNT_W-1:0]  csr_write_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_status,
   output logic [PAGE_W-1:0]      rsp_page_index_out,
   output logic [CNT_W-1:0]       rsp_free_pages
);

   // Bitmap: 1 = used
   logic used_mem [MAX_PAGES];

   cmd_type            cmd_ff;
   logic [PAGE_W-1:0]  idx_ff;
   logic [CNT_W-1:0]   len_ff;
   logic [PAGE_W-1:0]  low_ff, high_ff;
   logic [CNT_W-1:0]   count_ff, extent_ff;
   logic [ADDR_W-1:0]  p_ff;
   logic [CNT_W-1:0]   i_ff, k_ff;
   logic               ok_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic               rdata_ff, oob_ff;
   logic [PAGE_W-1:0]  fup_ff;
   logic [CNT_W-1:0]   pcnt_ff;
   logic               rsp_valid_ff, rsp_status_ff;
   logic [PAGE_W-1:0]  rsp_page_ff;
   logic [CNT_W-1:0]   rsp_free_ff;

   logic [CNT_W-1:0]   pc_eff, ext_eff, fill_target;
   logic [ADDR_W-1:0]  r8, rd_addr, wr_addr, free_end;
   logic               wr_en, wr_data;

   // Init geometry
   always_comb begin
      pc_eff  = (pcnt_ff > CNT_MAX) ? CNT_MAX : pcnt_ff;
      r8      = ({1'b0, pc_eff} + ADDR_W'(7)) & ~ADDR_W'(7);
      ext_eff = (r8 > ADDR_W'(CNT_MAX)) ? CNT_MAX : r8[CNT_W-1:0];
   end

   // Status
   always_comb begin
      fill_target    = (cmd_ff == CMD_INIT) ? CNT_MAX : len_ff;
      stat.one_live  = low_ff < high_ff;
      stat.run_live  = p_ff < ADDR_W'(high_ff);
      stat.run_fit   = i_ff == len_ff;
      stat.page_used = oob_ff | rdata_ff;
      stat.fill_done = k_ff == fill_target;
      stat.rsp_open  = !rsp_valid_ff || rsp_ready;
   end

   // Memory addressing
   always_comb begin
      rd_addr  = cmd.rd_one ? ADDR_W'(high_ff) : p_ff + ADDR_W'(i_ff);
      free_end = ADDR_W'(idx_ff) + ADDR_W'(len_ff) - ADDR_W'(1);
      wr_en    = 1'b0;
      wr_addr  = ADDR_W'(high_ff);
      wr_data  = 1'b1;
      if (cmd.one_hit) begin
         wr_en = 1'b1;
      end else if (cmd.fill_step) begin
         unique case (cmd_ff)
            CMD_INIT: begin
               wr_addr = ADDR_W'(k_ff);
               wr_data = (k_ff < CNT_W'(fup_ff)) || (k_ff >= pc_eff);
               wr_en   = 1'b1;
            end
            CMD_FREE: begin
               wr_addr = ADDR_W'(idx_ff) + ADDR_W'(k_ff);
               wr_data = 1'b0;
               wr_en   = wr_addr < ADDR_W'(extent_ff);
            end
            CMD_ALLOC_RUN: begin
               wr_addr = p_ff + ADDR_W'(k_ff);
               wr_data = 1'b1;
               wr_en   = wr_addr < ADDR_W'(extent_ff);
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   // Bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[wr_addr[PAGE_W-1:0]] <= wr_data;
      end
      if (cmd.rd_one || cmd.rd_run) begin
         rdata_ff <= used_mem[rd_addr[PAGE_W-1:0]];
         oob_ff   <= rd_addr >= ADDR_W'(extent_ff);
      end
   end

   // Payload latch and scan counters
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= cmd_type'(req_command);
         idx_ff  <= req_page_index;
         len_ff  <= req_run_length;
         p_ff    <= ADDR_W'(low_ff);
         i_ff    <= '0;
         k_ff    <= '0;
         page_ff <= '0;
      end
      if (cmd.run_used) begin
         p_ff <= p_ff + ADDR_W'(i_ff) + ADDR_W'(1);
         i_ff <= '0;
      end
      if (cmd.run_free) begin
         i_ff <= i_ff + CNT_W'(1);
      end
      if (cmd.fill_step) begin
         k_ff <= k_ff + CNT_W'(1);
      end
      if (cmd.one_hit) begin
         page_ff <= high_ff;
      end
      if (cmd.finish && cmd_ff == CMD_ALLOC_RUN && ok_ff) begin
         page_ff <= p_ff[PAGE_W-1:0];
      end
   end

   // Allocator state, config registers and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         count_ff     <= '0;
         extent_ff    <= '0;
         ok_ff        <= 1'b1;
         fup_ff       <= '0;
         pcnt_ff      <= CNT_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_FIRST_USABLE: fup_ff  <= csr_write_data[PAGE_W-1:0];
               CSR_PAGE_COUNT:   pcnt_ff <= csr_write_data;
               default:          fup_ff  <= fup_ff;
            endcase
         end
         if (cmd.load) begin
            ok_ff <= 1'b1;
         end
         if (cmd.fail) begin
            ok_ff <= 1'b0;
         end
         if (cmd.one_miss) begin
            high_ff <= high_ff - PAGE_W'(1);
         end
         if (cmd.one_hit) begin
            high_ff  <= high_ff - PAGE_W'(1);
            count_ff <= count_sub(count_ff, CNT_W'(1));
         end
         if (cmd.finish) begin
            unique case (cmd_ff)
               CMD_INIT: begin
                  extent_ff <= ext_eff;
                  count_ff  <= (pc_eff > CNT_W'(fup_ff)) ? pc_eff - CNT_W'(fup_ff) : '0;
                  low_ff    <= fup_ff;
                  high_ff   <= (pc_eff == '0) ? '0 : hint_clamp(ADDR_W'(pc_eff - CNT_W'(1)));
               end
               CMD_ALLOC_RUN: begin
                  if (ok_ff) begin
                     if (p_ff == ADDR_W'(low_ff)) begin
                        low_ff <= hint_clamp(ADDR_W'(low_ff) + ADDR_W'(len_ff));
                     end
                     count_ff <= count_sub(count_ff, len_ff);
                  end
               end
               CMD_FREE: begin
                  if (idx_ff < low_ff) begin
                     low_ff <= idx_ff;
                  end
                  if (len_ff != '0 && free_end > ADDR_W'(high_ff)) begin
                     high_ff <= hint_clamp(free_end);
                  end
                  count_ff <= count_add(count_ff, len_ff);
               end
               default: ok_ff <= ok_ff;
            endcase
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= !ok_ff;
         rsp_page_ff   <= ok_ff ? page_ff : '0;
         rsp_free_ff   <= count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_page_index_out = rsp_page_ff;
   assign rsp_free_pages     = rsp_free_ff;

endmodule
`default_nettype wire

[hw/rtl/page_bitmap_allocator.sv]
// Page bitmap allocator: up to 4096 pages, one used bit per page.
//
// Request beat (req_*): command, page_index, run_length, valid/ready.
// Response beat (rsp_*): status, page_index_out, free_pages, valid/ready.
// One response per request. Config writes (csr_*) take effect at once:
// index 0 first usable page, index 1 page count; write only while idle.
//
// Response time is set by the bitmap, walked one page per step:
//   init: all 4096 bitmap entries written, one bitmap entry written per cycle.
//   alloc one: check, read and evaluate states for each page tried down from the high hint,
//              also when no page is found.
//   alloc run: check, read and evaluate states for each page probed, then run_length marks;
//              the probe walk alone when no run fits.
//   free: run_length pages cleared.
// One request is in work at a time; the next request is taken as soon
// as the previous result sits in the response register.
// Reset: all pages read as used, counts and hints zero, page count 4096;
// no clearing pass, the map covers no page until the first init.
// A stalled receiver holds the response; the block finishes the next
// request and then waits for the response register to empty.
`default_nettype none
module page_bitmap_allocator
   import pba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [PAGE_W-1:0] req_page_index,
   input  wire logic [CNT_W-1:0]  req_run_length,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_status,
   output logic [PAGE_W-1:0]      rsp_page_index_out,
   output logic [CNT_W-1:0]       rsp_free_pages,
   input  wire logic              csr_write_enable,
   input  wire logic [0:0]        csr_index,
   input  wire logic [CNT_W-1:0]  csr_write_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd)
   );

   pba_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_command        (req_command),
      .req_page_index     (req_page_index),
      .req_run_length     (req_run_length),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_page_index_out (rsp_page_index_out),
      .rsp_free_pages     (rsp_free_pages)
   );

`include "page_bitmap_allocator_macros.svh"

   `PBA_ASSERT_CLK(a_free_bound, rsp_valid |-> rsp_free_pages <= CNT_MAX, "free count over limit")
   `PBA_ASSERT_CLK(a_fail_zero, (rsp_valid && rsp_status) |-> rsp_page_index_out == '0, "failed beat page")
   `PBA_ASSERT_CLK(a_busy_after, (req_valid && req_ready) |=> !req_ready, "ready after accept")
   `PBA_ASSERT_CLK(a_one_step, (cmd.respond) |-> stat.rsp_open, "response register overrun")

endmodule
`default_nettype wire

[tb/tb_page_bitmap_allocator.sv]
// Self-checking testbench for page_bitmap_allocator: directed and random commands,
// checked against an in-bench model of the page map. Depends on pba_pkg and the RTL.
module tb_page_bitmap_allocator;
   import pba_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      logic             status;
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  free_pages;
   } alloc_result_type;

   // Page map tracker: mirrors the bitmap, count and hints, queues expected beats
   class page_map_tracker;
      bit          used_map[MAX_PAGES];
      int unsigned free_cnt, low_hint, high_hint, extent;
      int unsigned first_usable, page_total;
      alloc_result_type pending[$];

      function new();
         foreach (used_map[i]) used_map[i] = 1'b1;
         free_cnt = 0; low_hint = 0; high_hint = 0; extent = 0;
         first_usable = 0; page_total = 4096;
      endfunction

      function void write_reg(csr_index_type idx, logic [CNT_W-1:0] data);
         if (idx == CSR_FIRST_USABLE) first_usable = data[PAGE_W-1:0];
         else page_total = data;
      endfunction

      function bit is_used(int unsigned p);
         if (p >= extent || p >= MAX_PAGES) return 1'b1;
         return used_map[p];
      endfunction

      function void mark(int unsigned p, bit v);
         if (p < extent && p < MAX_PAGES) used_map[p] = v;
      endfunction

      function int unsigned clamp_hint(int unsigned v);
         return (v > MAX_PAGES - 1) ? MAX_PAGES - 1 : v;
      endfunction

      function void take(int unsigned n);
         free_cnt = (n > free_cnt) ? 0 : free_cnt - n;
      endfunction

      // Compute the expected response for one accepted request beat
      function void note_request(cmd_type cmd, int unsigned idx, int unsigned len);
         alloc_result_type r;
         int unsigned pc, p, i;
         bit ok;
         ok = 1'b1;
         p = 0;
         r.page = '0;
         case (cmd)
            CMD_INIT: begin
               pc = (page_total > MAX_PAGES) ? MAX_PAGES : page_total;
               extent = (pc + 7) / 8 * 8;
               if (extent > MAX_PAGES) extent = MAX_PAGES;
               free_cnt = 0;
               for (int k = 0; k < MAX_PAGES; k++) begin
                  used_map[k] = (k < first_usable || k >= pc);
                  if (!used_map[k]) free_cnt++;
               end
               low_hint = clamp_hint(first_usable);
               high_hint = clamp_hint(pc == 0 ? 0 : pc - 1);
            end
            CMD_ALLOC_ONE: begin
               ok = 1'b0;
               while (!ok && low_hint < high_hint) begin
                  if (!is_used(high_hint)) begin
                     mark(high_hint, 1'b1);
                     r.page = high_hint[PAGE_W-1:0];
                     take(1);
                     ok = 1'b1;
                  end
                  high_hint--;
               end
            end
            CMD_ALLOC_RUN: begin
               ok = 1'b0;
               p = low_hint;
               while (!ok && p < high_hint) begin
                  i = 0;
                  while (i < len && !is_used(p + i)) i++;
                  if (i == len) begin
                     for (int k = 0; k < len; k++) mark(p + k, 1'b1);
                     if (p == low_hint) low_hint = clamp_hint(low_hint + len);
                     take(len);
                     r.page = p[PAGE_W-1:0];
                     ok = 1'b1;
                  end else begin
                     p = p + i + 1;
                  end
               end
            end
            default: begin
               for (int k = 0; k < len; k++) mark(idx + k, 1'b0);
               if (idx < low_hint) low_hint = idx;
               if (len != 0 && idx + len - 1 > high_hint) high_hint = clamp_hint(idx + len - 1);
               free_cnt = (free_cnt + len > MAX_PAGES) ? MAX_PAGES : free_cnt + len;
            end
         endcase
         r.status = ~ok;
         if (!ok) r.page = '0;
         r.free_pages = free_cnt[CNT_W-1:0];
         pending.push_back(r);
      endfunction

      // Compare one response beat with the oldest expectation
      function bit check_response(alloc_result_type got, output string why);
         alloc_result_type want;
         why = "";
         if (pending.size() == 0) begin
            why = "response beat with nothing expected";
            return 1'b0;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            why = $sformatf("status got %0b want %0b", got.status, want.status);
         else if (got.page !== want.page)
            why = $sformatf("page_index_out got %0d want %0d", got.page, want.page);
         else if (got.free_pages !== want.free_pages)
            why = $sformatf("free_pages got %0d want %0d", got.free_pages, want.free_pages);
         return why == "";
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_command = CMD_INIT;
   logic [PAGE_W-1:0] req_page_index = '0;
   logic [CNT_W-1:0]  req_run_length = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_status;
   logic [PAGE_W-1:0] rsp_page_index_out;
   logic [CNT_W-1:0]  rsp_free_pages;
   logic              csr_write_enable = 1'b0;
   logic [0:0]        csr_index = CSR_FIRST_USABLE;
   logic [CNT_W-1:0]  csr_write_data = '0;

   page_map_tracker tracker = new();
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_off = 0;

   page_bitmap_allocator dut (.*);

   always #10 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report(string why);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, why);
   endtask

   // Receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      alloc_result_type got;
      string why;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.page = rsp_page_index_out;
         got.free_pages = rsp_free_pages;
         if (!tracker.check_response(got, why)) report(why);
      end
   end

   // Offer one request beat, idling at random first; returns after acceptance
   task automatic send_req(cmd_type cmd, logic [PAGE_W-1:0] idx, logic [CNT_W-1:0] len);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_page_index <= idx;
      req_run_length <= len;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(cmd, idx, len);
   endtask

   // Stop offering and wait until every expected beat has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CNT_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tracker.write_reg(idx, data);
   endtask

   // One random command, sized mostly to a small map
   task automatic random_req(int unsigned span);
      int unsigned pick;
      logic [PAGE_W-1:0] idx;
      logic [CNT_W-1:0]  len;
      pick = $urandom_range(99);
      idx = PAGE_W'($urandom);
      len = CNT_W'($urandom);
      if (pick < 4) begin
         send_req(CMD_INIT, idx, len);
      end else if (pick < 36) begin
         send_req(CMD_ALLOC_ONE, idx, len);
      end else if (pick < 68) begin
         if ($urandom_range(99) >= 8) len = CNT_W'($urandom_range(0, 12));
         send_req(CMD_ALLOC_RUN, idx, len);
      end else begin
         if ($urandom_range(99) >= 10) idx = PAGE_W'($urandom_range(0, span + 8));
         if ($urandom_range(99) >= 5) len = CNT_W'($urandom_range(0, 10));
         send_req(CMD_FREE, idx, len);
      end
   endtask

   initial begin
      int unsigned span;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Before any init: every page lies outside the map
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd0);
      send_req(CMD_FREE, 12'd5, 13'd3);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd2);
      send_req(CMD_ALLOC_ONE, 12'hFFF, 13'h1FFF);
      drain();

      // Full map
      write_csr(CSR_FIRST_USABLE, 13'd0);
      write_csr(CSR_PAGE_COUNT, 13'd4096);
      send_req(CMD_INIT, 12'd0, 13'd0);
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd0);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd4096);
      send_req(CMD_FREE, 12'd4095, 13'd4096);
      send_req(CMD_FREE, 12'd0, 13'd0);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd1);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'h1FFF);
      drain();

      // Top usable page with a tiny map, then no pages, then an oversized count
      write_csr(CSR_FIRST_USABLE, 13'h1FFF);
      write_csr(CSR_PAGE_COUNT, 13'd1);
      send_req(CMD_INIT, 12'd0, 13'd0);
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      send_req(CMD_ALLOC_RUN, 12'd0, 13'd1);
      drain();
      write_csr(CSR_FIRST_USABLE, 13'd0);
      write_csr(CSR_PAGE_COUNT, 13'd0);
      send_req(CMD_INIT, 12'd0, 13'd0);
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      send_req(CMD_FREE, 12'd2, 13'd4);
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      drain();
      write_csr(CSR_PAGE_COUNT, 13'h1FFF);
      send_req(CMD_INIT, 12'd0, 13'd0);
      send_req(CMD_ALLOC_ONE, 12'd0, 13'd0);
      drain();

      // Random phases over small maps, cycling the idle patterns
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         span = $urandom_range(8, 80);
         write_csr(CSR_FIRST_USABLE, CNT_W'($urandom_range(0, 20)));
         write_csr(CSR_PAGE_COUNT, CNT_W'(span));
         send_req(CMD_INIT, PAGE_W'($urandom), CNT_W'($urandom));
         // Long receiver hold-off so the block backs up into its input
         if (ph == 2) hold_off = 300;
         repeat (15) random_req(span);
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
